FILE: hw/rtl/shelf_atlas_cell_allocator_defines.svh
// Assertion macros shared by the atlas allocator RTL.
`ifndef SHELF_ATLAS_CELL_ALLOCATOR_DEFINES_SVH
`define SHELF_ATLAS_CELL_ALLOCATOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define SACA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SACA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/saca_pkg.sv
// Types, codes and constants of the shelf atlas cell allocator.
`default_nettype none

package saca_pkg;

  localparam int PAGE_PIXELS_DEF   = 2048;
  localparam int TEXTURE_SLOTS_DEF = 4096;
  localparam int MAX_PAGES_DEF     = 16;

  localparam int DIM_CAP   = 128;
  localparam int BORDER_PX = 1;
  localparam int GAP_PX    = 1;

  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 12;
  localparam int DIM_W      = 12;
  localparam int STATUS_W   = 2;
  localparam int PAGE_W     = 4;
  localparam int COORD_W    = 11;
  localparam int CELL_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_PACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_EXIST  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEW    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM = 1'b1;

  localparam logic [CFG_DATA_W-1:0] MAX_DIM_RESET = 8'd128;

  // One entry of the slot memory: flags plus the cell placed for the slot.
  typedef struct packed {
    logic               is_rejected;
    logic               is_packed;
    logic [PAGE_W-1:0]  page;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CELL_W-1:0]  w;
    logic [CELL_W-1:0]  h;
  } cell_word_t;

  localparam int CELL_WORD_W = $bits(cell_word_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_index;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [CELL_W-1:0]   cell_width;
    logic [CELL_W-1:0]   cell_height;
    logic                page_stale;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/saca_if.sv
// Request, response and configuration channels of the atlas allocator.
`default_nettype none

interface saca_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [saca_pkg::KIND_W-1:0]          kind;
  logic [saca_pkg::INDEX_W-1:0]         texture_index;
  logic [saca_pkg::DIM_W-1:0]           width;
  logic [saca_pkg::DIM_W-1:0]           height;
  logic                                 eligible;

  modport source (output valid, kind, texture_index, width, height, eligible,
                  input ready);
  modport sink   (input valid, kind, texture_index, width, height, eligible,
                  output ready);
endinterface

interface saca_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [saca_pkg::STATUS_W-1:0]        status;
  logic [saca_pkg::PAGE_W-1:0]          page_index;
  logic [saca_pkg::COORD_W-1:0]         cell_x;
  logic [saca_pkg::COORD_W-1:0]         cell_y;
  logic [saca_pkg::CELL_W-1:0]          cell_width;
  logic [saca_pkg::CELL_W-1:0]          cell_height;
  logic                                 page_stale;

  modport source (output valid, status, page_index, cell_x, cell_y, cell_width,
                  cell_height, page_stale, input ready);
  modport sink   (input valid, status, page_index, cell_x, cell_y, cell_width,
                  cell_height, page_stale, output ready);
endinterface

interface saca_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [saca_pkg::CFG_IDX_W-1:0]       index;
  logic [saca_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/saca_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module saca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/shelf_atlas_cell_allocator.sv
// Top level of the shelf atlas cell allocator.
//
// Packs sprite cells (texture plus a one-pixel border, one pixel of spacing) onto
// shelves of square pages of PAGE_PIXELS pixels, remembers the cell of every texture
// slot and answers one response per request. The accept cycle of a request reads the
// slot's entry from the slot memory, the next cycle decides, writes the entry back
// and moves the shelf registers. A response that cannot leave yet is parked in a skid
// register, and the next request is taken once that register is empty. After reset
// and after every clear request the slot memory is swept, one entry a cycle, over all
// TEXTURE_SLOTS entries; no request is taken during the sweep, configuration writes
// are taken at any time.
`default_nettype none

`include "shelf_atlas_cell_allocator_defines.svh"

module shelf_atlas_cell_allocator #(
  parameter int PAGE_PIXELS   = saca_pkg::PAGE_PIXELS_DEF,
  parameter int TEXTURE_SLOTS = saca_pkg::TEXTURE_SLOTS_DEF,
  parameter int MAX_PAGES     = saca_pkg::MAX_PAGES_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  saca_req_if.sink    req,
  saca_rsp_if.source  rsp,
  saca_cfg_if.sink    cfg
);

  localparam int AW = $clog2(TEXTURE_SLOTS);
  localparam int PW = $clog2(PAGE_PIXELS + 1);
  localparam int SW = PW + 1;
  localparam int GW = $clog2(MAX_PAGES + 1);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state;
  logic [AW-1:0] sweep_addr;

  // captured request
  logic [saca_pkg::KIND_W-1:0]  req_kind;
  logic [saca_pkg::INDEX_W-1:0] req_index;
  logic [saca_pkg::DIM_W-1:0]   req_w;
  logic [saca_pkg::DIM_W-1:0]   req_h;
  logic                         req_ok;

  logic                              enable;
  logic [saca_pkg::CFG_DATA_W-1:0]   max_dim;

  logic [GW-1:0]                 pages_open;
  logic [PW-1:0]                 shelf_x;
  logic [PW-1:0]                 shelf_y;
  logic [saca_pkg::CELL_W-1:0]   shelf_h;

  logic                 out_valid;
  saca_pkg::result_t    out_res;
  logic                 pend_valid;
  saca_pkg::result_t    pend_res;

  // slot memory ports
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  saca_pkg::cell_word_t           mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [saca_pkg::CELL_WORD_W-1:0] mem_rdata;

  // decision of the read cycle
  saca_pkg::cell_word_t         word;
  saca_pkg::result_t            res;
  saca_pkg::cell_word_t         wb_word;
  logic                         wb_en;
  logic                         shelf_upd;
  logic [saca_pkg::CELL_W-1:0]  lim;
  logic                         in_range;
  logic                         bad_size;
  logic [saca_pkg::CELL_W-1:0]  cw;
  logic [saca_pkg::CELL_W-1:0]  ch;
  logic [GW-1:0]                pg;
  logic [PW-1:0]                sx;
  logic [PW-1:0]                sy;
  logic [saca_pkg::CELL_W-1:0]  sh;
  logic [PW-1:0]                cx;
  logic [PW-1:0]                cy;
  logic                         place_ok;
  logic [PW-1:0]                sx_next;
  logic [saca_pkg::CELL_W-1:0]  sh_next;

  logic req_fire;
  logic out_free;

  assign req.ready = (state == ST_IDLE) && !pend_valid;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_res.status;
  assign rsp.page_index  = out_res.page_index;
  assign rsp.cell_x      = out_res.cell_x;
  assign rsp.cell_y      = out_res.cell_y;
  assign rsp.cell_width  = out_res.cell_width;
  assign rsp.cell_height = out_res.cell_height;
  assign rsp.page_stale  = out_res.page_stale;

  assign word = saca_pkg::cell_word_t'(mem_rdata);

  always_comb begin
    lim = (max_dim > saca_pkg::CELL_W'(saca_pkg::DIM_CAP)) ?
          saca_pkg::CELL_W'(saca_pkg::DIM_CAP) : max_dim;
    in_range = int'(req_index) < TEXTURE_SLOTS;
    bad_size = !req_ok || (req_w == '0) || (req_h == '0) ||
               (req_w > saca_pkg::DIM_W'(lim)) || (req_h > saca_pkg::DIM_W'(lim));
    cw = req_w[saca_pkg::CELL_W-1:0] + saca_pkg::CELL_W'(2 * saca_pkg::BORDER_PX);
    ch = req_h[saca_pkg::CELL_W-1:0] + saca_pkg::CELL_W'(2 * saca_pkg::BORDER_PX);

    pg = pages_open;
    sx = shelf_x;
    sy = shelf_y;
    sh = shelf_h;
    // open the first page on demand
    if (pages_open == '0) begin
      pg = GW'(1);
      sx = PW'(saca_pkg::GAP_PX);
      sy = PW'(saca_pkg::GAP_PX);
      sh = '0;
    end
    // start a new shelf when the cell runs past the right edge
    if (SW'(sx) + SW'(cw) + SW'(saca_pkg::GAP_PX) > SW'(PAGE_PIXELS)) begin
      sy = PW'(SW'(sy) + SW'(sh) + SW'(saca_pkg::GAP_PX));
      sx = PW'(saca_pkg::GAP_PX);
      sh = '0;
    end
    cx = sx;
    cy = sy;
    place_ok = (SW'(sy) + SW'(ch) + SW'(saca_pkg::GAP_PX)) <= SW'(PAGE_PIXELS);
    // a fresh page always takes a cell of at most the capped size
    if (!place_ok && (pg < GW'(MAX_PAGES))) begin
      pg = pg + GW'(1);
      sx = PW'(saca_pkg::GAP_PX);
      sy = PW'(saca_pkg::GAP_PX);
      sh = '0;
      cx = PW'(saca_pkg::GAP_PX);
      cy = PW'(saca_pkg::GAP_PX);
      place_ok = 1'b1;
    end
    sx_next = place_ok ? PW'(SW'(sx) + SW'(cw) + SW'(saca_pkg::GAP_PX)) : sx;
    sh_next = (place_ok && (ch > sh)) ? ch : sh;

    res       = '0;
    wb_word   = '0;
    wb_en     = 1'b0;
    shelf_upd = 1'b0;
    if (req_kind == saca_pkg::KIND_CLEAR) begin
      res.status = saca_pkg::STATUS_ABSENT;
    end else if (((req_kind != saca_pkg::KIND_PACK) && (req_kind != saca_pkg::KIND_LOOKUP))
                 || !enable || !in_range) begin
      res.status = saca_pkg::STATUS_ABSENT;
    end else if (word.is_packed) begin
      res.status      = saca_pkg::STATUS_EXIST;
      res.page_index  = word.page;
      res.cell_x      = word.x;
      res.cell_y      = word.y;
      res.cell_width  = word.w;
      res.cell_height = word.h;
    end else if (req_kind == saca_pkg::KIND_LOOKUP) begin
      res.status = saca_pkg::STATUS_ABSENT;
    end else if (word.is_rejected) begin
      res.status = saca_pkg::STATUS_REJECT;
    end else if (bad_size) begin
      res.status          = saca_pkg::STATUS_REJECT;
      wb_en               = 1'b1;
      wb_word.is_rejected = 1'b1;
    end else begin
      // shelf moves stay even when the pages run out
      shelf_upd = 1'b1;
      wb_en     = 1'b1;
      if (!place_ok) begin
        res.status          = saca_pkg::STATUS_REJECT;
        wb_word.is_rejected = 1'b1;
      end else begin
        wb_word.is_packed = 1'b1;
        wb_word.page      = saca_pkg::PAGE_W'(pg - GW'(1));
        wb_word.x         = saca_pkg::COORD_W'(cx);
        wb_word.y         = saca_pkg::COORD_W'(cy);
        wb_word.w         = cw;
        wb_word.h         = ch;
        res.status        = saca_pkg::STATUS_NEW;
        res.page_index    = wb_word.page;
        res.cell_x        = wb_word.x;
        res.cell_y        = wb_word.y;
        res.cell_width    = cw;
        res.cell_height   = ch;
        res.page_stale    = 1'b1;
      end
    end
  end

  always_comb begin
    mem_re    = req_fire;
    mem_raddr = AW'(req.texture_index);
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == ST_READ) && wb_en;
      mem_waddr = AW'(req_index);
      mem_wdata = wb_word;
    end
  end

  saca_ram #(
    .WIDTH (saca_pkg::CELL_WORD_W),
    .DEPTH (TEXTURE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      enable     <= 1'b1;
      max_dim    <= saca_pkg::MAX_DIM_RESET;
      pages_open <= '0;
      shelf_x    <= PW'(saca_pkg::GAP_PX);
      shelf_y    <= PW'(saca_pkg::GAP_PX);
      shelf_h    <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          saca_pkg::REG_ENABLE:  enable  <= cfg.data[0];
          saca_pkg::REG_MAX_DIM: max_dim <= cfg.data;
        endcase
      end

      // response register with a skid stage behind it
      if (out_free) begin
        if (pend_valid) begin
          out_res    <= pend_res;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (state == ST_READ) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (state == ST_READ) begin
        pend_res   <= res;
        pend_valid <= 1'b1;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(TEXTURE_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            req_kind  <= req.kind;
            req_index <= req.texture_index;
            req_w     <= req.width;
            req_h     <= req.height;
            req_ok    <= req.eligible;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          if (req_kind == saca_pkg::KIND_CLEAR) begin
            pages_open <= '0;
            shelf_x    <= PW'(saca_pkg::GAP_PX);
            shelf_y    <= PW'(saca_pkg::GAP_PX);
            shelf_h    <= '0;
            sweep_addr <= '0;
            state      <= ST_SWEEP;
          end else begin
            if (shelf_upd) begin
              pages_open <= pg;
              shelf_x    <= sx_next;
              shelf_y    <= sy;
              shelf_h    <= sh_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

  `SACA_ASSERT_IMPLY(a_read_no_pend, state == ST_READ, !pend_valid, "skid register busy while deciding")
  `SACA_ASSERT_IMPLY(a_pend_behind_out, pend_valid, out_valid, "skid register filled ahead of output")
  `SACA_ASSERT_ALWAYS(a_shelf_in_page, SW'(shelf_x) <= SW'(PAGE_PIXELS) && SW'(shelf_y) <= SW'(PAGE_PIXELS), "shelf outside page")
  `SACA_ASSERT_ALWAYS(a_pages_bound, pages_open <= GW'(MAX_PAGES), "page count past limit")
  `SACA_ASSERT_IMPLY(a_stale_on_new, rsp.valid, rsp.page_stale == (rsp.status == saca_pkg::STATUS_NEW), "stale flag out of step with status")

endmodule

`default_nettype wire

FILE: verif/tb_shelf_atlas_cell_allocator.sv
// Self-checking testbench for the shelf atlas cell allocator, with its own placement model.
module tb_shelf_atlas_cell_allocator;

  localparam logic [saca_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 40;
  localparam int PHASE_ITEMS    = 135;

  typedef struct packed {
    logic [saca_pkg::KIND_W-1:0]  kind;
    logic [saca_pkg::INDEX_W-1:0] texture_index;
    logic [saca_pkg::DIM_W-1:0]   width;
    logic [saca_pkg::DIM_W-1:0]   height;
    logic                         eligible;
  } request_t;

  logic clk = 1'b0;
  logic rst;

  saca_req_if req_ch();
  saca_rsp_if rsp_ch();
  saca_cfg_if cfg_ch();

  shelf_atlas_cell_allocator u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Mirror of the allocator state
  logic                            model_enable;
  logic [saca_pkg::CFG_DATA_W-1:0] model_max_dim;
  int unsigned                     page_count;
  int unsigned                     pen_x;
  int unsigned                     pen_y;
  int unsigned                     row_height;
  saca_pkg::cell_word_t            slot_entries [saca_pkg::TEXTURE_SLOTS_DEF];

  saca_pkg::result_t pending_answers[$];
  int unsigned       errors;
  bit                sender_gaps;
  bit                receiver_stalls;
  int unsigned       rsp_hold_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void wipe_atlas();
    page_count = 0;
    pen_x = saca_pkg::GAP_PX;
    pen_y = saca_pkg::GAP_PX;
    row_height = 0;
    foreach (slot_entries[i]) slot_entries[i] = '0;
  endfunction

  function automatic void start_page();
    page_count++;
    pen_x = saca_pkg::GAP_PX;
    pen_y = saca_pkg::GAP_PX;
    row_height = 0;
  endfunction

  // Place on the current shelf, opening a new shelf first when the row is full.
  function automatic bit try_place(input int unsigned cw, ch,
                                   output int unsigned cx, cy);
    if (pen_x + cw + saca_pkg::GAP_PX > saca_pkg::PAGE_PIXELS_DEF) begin
      pen_y += row_height + saca_pkg::GAP_PX;
      pen_x = saca_pkg::GAP_PX;
      row_height = 0;
    end
    if (pen_y + ch + saca_pkg::GAP_PX > saca_pkg::PAGE_PIXELS_DEF) return 1'b0;
    cx = pen_x;
    cy = pen_y;
    pen_x += cw + saca_pkg::GAP_PX;
    if (ch > row_height) row_height = ch;
    return 1'b1;
  endfunction

  function automatic saca_pkg::result_t atlas_answer(input request_t r);
    saca_pkg::result_t    a;
    saca_pkg::cell_word_t word;
    int unsigned          lim;
    int unsigned          cw;
    int unsigned          ch;
    int unsigned          cx;
    int unsigned          cy;
    bit                   placed;
    a = '0;
    a.status = saca_pkg::STATUS_ABSENT;
    if (r.kind == saca_pkg::KIND_CLEAR) begin
      wipe_atlas();
      return a;
    end
    if (r.kind == KIND_RESERVED || !model_enable) return a;
    word = slot_entries[r.texture_index];
    if (word.is_packed) begin
      a.status      = saca_pkg::STATUS_EXIST;
      a.page_index  = word.page;
      a.cell_x      = word.x;
      a.cell_y      = word.y;
      a.cell_width  = word.w;
      a.cell_height = word.h;
      return a;
    end
    if (r.kind == saca_pkg::KIND_LOOKUP) return a;
    a.status = saca_pkg::STATUS_REJECT;
    if (word.is_rejected) return a;
    lim = (model_max_dim > saca_pkg::DIM_CAP) ? saca_pkg::DIM_CAP : model_max_dim;
    placed = 1'b0;
    if (r.eligible && r.width != 0 && r.height != 0 && r.width <= lim && r.height <= lim) begin
      cw = r.width + 2 * saca_pkg::BORDER_PX;
      ch = r.height + 2 * saca_pkg::BORDER_PX;
      if (page_count == 0) start_page();
      placed = try_place(cw, ch, cx, cy);
      // the shelf move made by the failed attempt stays
      if (!placed && page_count < saca_pkg::MAX_PAGES_DEF) begin
        start_page();
        placed = try_place(cw, ch, cx, cy);
      end
    end
    word = '0;
    if (!placed) begin
      word.is_rejected = 1'b1;
      slot_entries[r.texture_index] = word;
      return a;
    end
    word.is_packed = 1'b1;
    word.page      = saca_pkg::PAGE_W'(page_count - 1);
    word.x         = saca_pkg::COORD_W'(cx);
    word.y         = saca_pkg::COORD_W'(cy);
    word.w         = saca_pkg::CELL_W'(cw);
    word.h         = saca_pkg::CELL_W'(ch);
    slot_entries[r.texture_index] = word;
    a.status      = saca_pkg::STATUS_NEW;
    a.page_index  = word.page;
    a.cell_x      = word.x;
    a.cell_y      = word.y;
    a.cell_width  = word.w;
    a.cell_height = word.h;
    a.page_stale  = 1'b1;
    return a;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want, got);
    if (want != got) begin
      errors++;
      // keep the log short when everything goes wrong
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Predict on every accepted request, check every accepted response.
  always @(posedge clk) begin
    request_t          seen;
    saca_pkg::result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          saca_pkg::REG_ENABLE:  model_enable = cfg_ch.data[0];
          saca_pkg::REG_MAX_DIM: model_max_dim = cfg_ch.data;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.kind          = req_ch.kind;
        seen.texture_index = req_ch.texture_index;
        seen.width         = req_ch.width;
        seen.height        = req_ch.height;
        seen.eligible      = req_ch.eligible;
        pending_answers.push_back(atlas_answer(seen));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none actual status %0d",
                   $time, rsp_ch.status);
        end else begin
          want = pending_answers.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_ch.status));
          compare_field("page_index", 32'(want.page_index), 32'(rsp_ch.page_index));
          compare_field("cell_x", 32'(want.cell_x), 32'(rsp_ch.cell_x));
          compare_field("cell_y", 32'(want.cell_y), 32'(rsp_ch.cell_y));
          compare_field("cell_width", 32'(want.cell_width), 32'(rsp_ch.cell_width));
          compare_field("cell_height", 32'(want.cell_height), 32'(rsp_ch.cell_height));
          compare_field("page_stale", 32'(want.page_stale), 32'(rsp_ch.page_stale));
        end
      end
    end
  end

  // Response side: random stall bursts, or one long hold when asked.
  initial begin
    forever begin
      if (rsp_hold_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic post_request(input logic [saca_pkg::KIND_W-1:0] kind,
                              input int unsigned idx, w, h, input bit ok);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.texture_index <= saca_pkg::INDEX_W'(idx);
    req_ch.width         <= saca_pkg::DIM_W'(w);
    req_ch.height        <= saca_pkg::DIM_W'(h);
    req_ch.eligible      <= ok;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; the block must be idle.
  task automatic write_settings(input logic [saca_pkg::CFG_DATA_W-1:0] enable_word, max_dim);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= saca_pkg::REG_ENABLE;
    cfg_ch.data  <= enable_word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= saca_pkg::REG_MAX_DIM;
    cfg_ch.data  <= max_dim;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int unsigned random_dimension();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 4095);
      1:       return $urandom_range(0, 1) ? 0 : $urandom_range(129, 300);
      default: return $urandom_range(1, 128);
    endcase
  endfunction

  task automatic test_directed_cases();
    post_request(saca_pkg::KIND_PACK, 0, 1, 1, 1'b1);
    post_request(saca_pkg::KIND_PACK, 4095, 128, 128, 1'b1);
    post_request(saca_pkg::KIND_PACK, 0, 7, 9, 1'b1);
    post_request(saca_pkg::KIND_LOOKUP, 4095, 0, 0, 1'b0);
    post_request(saca_pkg::KIND_LOOKUP, 10, 5, 5, 1'b1);
    post_request(saca_pkg::KIND_PACK, 11, 4, 4, 1'b0);
    // refused without a second look at the size
    post_request(saca_pkg::KIND_PACK, 11, 4, 4, 1'b1);
    post_request(saca_pkg::KIND_LOOKUP, 11, 4, 4, 1'b1);
    post_request(saca_pkg::KIND_PACK, 12, 0, 5, 1'b1);
    post_request(saca_pkg::KIND_PACK, 13, 5, 0, 1'b1);
    post_request(saca_pkg::KIND_PACK, 14, 129, 5, 1'b1);
    post_request(saca_pkg::KIND_PACK, 15, 4095, 4095, 1'b1);
    post_request(saca_pkg::KIND_PACK, 17, 128, 1, 1'b1);
    post_request(KIND_RESERVED, 0, 4095, 4095, 1'b1);
    post_request(saca_pkg::KIND_CLEAR, 4095, 4095, 4095, 1'b1);
    post_request(saca_pkg::KIND_LOOKUP, 0, 1, 1, 1'b1);
    post_request(saca_pkg::KIND_PACK, 0, 2, 3, 1'b1);
    wait_all_answered();
  endtask

  task automatic test_register_settings();
    // enable off, upper data bits set: only clear acts
    write_settings(8'hFE, saca_pkg::MAX_DIM_RESET);
    post_request(saca_pkg::KIND_PACK, 0, 3, 3, 1'b1);
    post_request(saca_pkg::KIND_PACK, 20, 3, 3, 1'b1);
    post_request(saca_pkg::KIND_CLEAR, 0, 0, 0, 1'b0);
    wait_all_answered();
    write_settings(8'h01, 8'd0);
    post_request(saca_pkg::KIND_PACK, 21, 1, 1, 1'b1);
    wait_all_answered();
    write_settings(8'h01, 8'hFF);
    post_request(saca_pkg::KIND_PACK, 22, 128, 128, 1'b1);
    post_request(saca_pkg::KIND_PACK, 23, 129, 4, 1'b1);
    wait_all_answered();
    write_settings(8'h01, 8'd1);
    post_request(saca_pkg::KIND_PACK, 24, 1, 1, 1'b1);
    post_request(saca_pkg::KIND_PACK, 25, 2, 1, 1'b1);
    post_request(saca_pkg::KIND_PACK, 26, 1, 2, 1'b1);
    wait_all_answered();
    write_settings(8'h01, saca_pkg::MAX_DIM_RESET);
  endtask

  task automatic test_back_pressure();
    rsp_hold_cycles = 300;
    repeat (24)
      post_request(saca_pkg::KIND_PACK, $urandom_range(0, 255), $urandom_range(1, 64),
                   $urandom_range(1, 64), 1'b1);
    // hold the sender until every response is in
    wait_all_answered();
    repeat (8)
      post_request(saca_pkg::KIND_LOOKUP, $urandom_range(0, 255), 0, 0, 1'b1);
    wait_all_answered();
  endtask

  task automatic test_page_rollover();
    int unsigned slot;
    int unsigned extra;
    post_request(saca_pkg::KIND_CLEAR, 0, 0, 0, 1'b0);
    slot = 0;
    extra = 0;
    // large cells fill the first page; go on a little onto the second
    while (slot < saca_pkg::TEXTURE_SLOTS_DEF - 16 && extra < 8) begin
      if ($urandom_range(0, 15) == 0)
        post_request(saca_pkg::KIND_LOOKUP, $urandom_range(0, slot), 0, 0, 1'b1);
      post_request(saca_pkg::KIND_PACK, slot, $urandom_range(120, 128), 128, 1'b1);
      slot++;
      if (page_count > 1) extra++;
    end
    // small cells join the shelf of the large ones
    repeat (6) begin
      post_request(saca_pkg::KIND_PACK, slot, $urandom_range(1, 4), $urandom_range(1, 4), 1'b1);
      slot++;
    end
    wait_all_answered();
  endtask

  task automatic test_random_mix();
    int unsigned                 pick;
    logic [saca_pkg::KIND_W-1:0] kind;
    int unsigned                 idx;
    post_request(saca_pkg::KIND_CLEAR, 0, 0, 0, 1'b0);
    wait_all_answered();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_settings(8'h01, saca_pkg::MAX_DIM_RESET);
        1: write_settings(8'h01, saca_pkg::CFG_DATA_W'($urandom_range(16, 255)));
        2: write_settings(saca_pkg::CFG_DATA_W'($urandom_range(0, 255)),
                          saca_pkg::CFG_DATA_W'($urandom_range(0, 255)));
        default: begin
          write_settings(8'hFF, 8'hFF);
          sender_gaps = 1'b0;
          receiver_stalls = 1'b0;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)      kind = saca_pkg::KIND_PACK;
        else if (pick < 94) kind = saca_pkg::KIND_LOOKUP;
        else if (pick < 99) kind = KIND_RESERVED;
        else                kind = saca_pkg::KIND_CLEAR;
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
        post_request(kind, idx, random_dimension(), random_dimension(),
                     $urandom_range(0, 9) != 0);
      end
      wait_all_answered();
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= saca_pkg::KIND_PACK;
    req_ch.texture_index <= '0;
    req_ch.width         <= '0;
    req_ch.height        <= '0;
    req_ch.eligible      <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= saca_pkg::REG_ENABLE;
    cfg_ch.data          <= '0;
    errors = 0;
    rsp_hold_cycles = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    model_enable = 1'b1;
    model_max_dim = saca_pkg::MAX_DIM_RESET;
    wipe_atlas();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_settings();
    test_back_pressure();
    test_page_rollover();
    test_random_mix();

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: shelf_atlas_cell_allocator.f
+incdir+hw/rtl
hw/rtl/saca_pkg.sv
hw/rtl/saca_if.sv
hw/rtl/saca_ram.sv
hw/rtl/shelf_atlas_cell_allocator.sv
verif/tb_shelf_atlas_cell_allocator.sv
